### src/chlo_pkg.sv
package chlo_pkg;

  localparam int unsigned SENS_W = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SENS_W-1:0] SENS_XY_RST = 12'd670;
  localparam logic [SENS_W-1:0] SENS_Z_RST  = 12'd600;

  // tan(22.5 deg) and tan(67.5 deg) in Q32
  localparam logic [63:0] TAN22_Q32 = 64'd1779033704;
  localparam logic [63:0] TAN67_Q32 = 64'd10368968296;

  localparam logic [7:0] MASK_NOISY = 8'h99;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE  = 2'd0,
    CFG_SENS_XY = 2'd1,
    CFG_SENS_Z  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              enable;
    logic [SENS_W-1:0] sens_xy;
    logic [SENS_W-1:0] sens_z;
  } cfg_t;

  // LED maps indexed by sector, sector 2 is the one for level 0 (near the x axis)
  localparam logic [4:0][7:0] MAP_POS = {8'h10, 8'h40, 8'h80, 8'h20, 8'h08};
  localparam logic [4:0][7:0] MAP_NEG = {8'h08, 8'h02, 8'h01, 8'h04, 8'h10};

endpackage

### src/chlo_cfg_regs.sv
module chlo_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [chlo_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [chlo_pkg::SENS_W-1:0]     cfg_wdata_i,
  output chlo_pkg::cfg_t                  cfg_o
);

  chlo_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        chlo_pkg::CFG_ENABLE:  cfg_d.enable  = cfg_wdata_i[0];
        chlo_pkg::CFG_SENS_XY: cfg_d.sens_xy = cfg_wdata_i;
        chlo_pkg::CFG_SENS_Z:  cfg_d.sens_z  = cfg_wdata_i;
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable  <= 1'b0;
      cfg_q.sens_xy <= chlo_pkg::SENS_XY_RST;
      cfg_q.sens_z  <= chlo_pkg::SENS_Z_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/compass_heading_led_octant_core.sv
// Compass heading LED indicator. Each request carries one raw magnetometer
// sample and returns one 8-bit LED mask plus a tilt/noise flag. The datapath
// is a five-stage pipeline: signs and magnitudes, squares and
// tangent products, sector choice and horizontal sum, the two 32x24 test
// products, then the scale and compare into the output register. A sample
// is accepted every cycle unless the output stalls; the whole pipeline holds
// while a result waits on m_axis_tready. Configuration writes take effect at
// once and are meant to be made with the pipeline empty.
module compass_heading_led_octant_core #(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned TAN_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // mag_x [15:0], mag_y [31:16], mag_z [47:32]
  input  logic [47:0]                    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // led_mask [7:0]
  output logic [7:0]                     m_axis_tdata,
  // tilt_noisy [0]
  output logic                           m_axis_tuser,
  input  logic                           cfg_we_i,
  input  logic [chlo_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [chlo_pkg::SENS_W-1:0]    cfg_wdata_i
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned TF    = TAN_FRAC_BITS;
  localparam int unsigned SQW   = 2 * SB;
  localparam int unsigned S2W   = 2 * chlo_pkg::SENS_W;
  localparam int unsigned TANW  = TF + 2;
  localparam int unsigned PW    = TANW + SB;
  localparam int unsigned MW    = SQW + S2W;
  localparam int unsigned CW    = MW + 6;
  localparam int unsigned TSH   = 32 - TF;

  localparam logic [63:0] T22_FULL =
    (chlo_pkg::TAN22_Q32 + (64'd1 << (TSH - 1))) >> TSH;
  localparam logic [63:0] T67_FULL =
    (chlo_pkg::TAN67_Q32 + (64'd1 << (TSH - 1))) >> TSH;
  localparam logic [TANW-1:0] T22 = T22_FULL[TANW-1:0];
  localparam logic [TANW-1:0] T67 = T67_FULL[TANW-1:0];

  chlo_pkg::cfg_t cfg;

  chlo_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  assign adv           = !v5_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // stage 1: signs, magnitudes, sensitivity squares
  logic [SB-1:0] x_raw, y_raw, z_raw;
  logic [SB-1:0] ax_d, ay_d, az_d;
  logic          neg_d, xpos_d;

  assign x_raw  = s_axis_tdata[SB-1:0];
  assign y_raw  = s_axis_tdata[16+SB-1:16];
  assign z_raw  = s_axis_tdata[32+SB-1:32];
  assign ax_d   = x_raw[SB-1] ? (~x_raw + 1'b1) : x_raw;
  assign ay_d   = y_raw[SB-1] ? (~y_raw + 1'b1) : y_raw;
  assign az_d   = z_raw[SB-1] ? (~z_raw + 1'b1) : z_raw;
  assign neg_d  = x_raw[SB-1] ^ y_raw[SB-1];
  assign xpos_d = !x_raw[SB-1] && (x_raw != '0);

  logic [SB-1:0]  ax_q, ay_q, az_q;
  logic           neg1_q, xpos1_q;
  logic [S2W-1:0] sxy2_1_q, sz2_1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q     <= ax_d;
      ay_q     <= ay_d;
      az_q     <= az_d;
      neg1_q   <= neg_d;
      xpos1_q  <= xpos_d;
      sxy2_1_q <= S2W'(cfg.sens_xy) * S2W'(cfg.sens_xy);
      sz2_1_q  <= S2W'(cfg.sens_z) * S2W'(cfg.sens_z);
    end
  end

  // stage 2: squares and tangent products
  logic [SQW-1:0] ax2_q, ay2_q, az2_2_q;
  logic [PW-1:0]  p22_q, p67_q, a_q;
  logic           neg2_q, xpos2_q, nz2_q;
  logic [S2W-1:0] sxy2_2_q, sz2_2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax2_q    <= SQW'(ax_q) * SQW'(ax_q);
      ay2_q    <= SQW'(ay_q) * SQW'(ay_q);
      az2_2_q  <= SQW'(az_q) * SQW'(az_q);
      p22_q    <= PW'(T22) * PW'(ax_q);
      p67_q    <= PW'(T67) * PW'(ax_q);
      a_q      <= PW'(ay_q) << TF;
      neg2_q   <= neg1_q;
      xpos2_q  <= xpos1_q;
      nz2_q    <= (ax_q != '0) || (ay_q != '0);
      sxy2_2_q <= sxy2_1_q;
      sz2_2_q  <= sz2_1_q;
    end
  end

  // stage 3: horizontal sum and sector choice
  logic [2:0] idx;
  logic [7:0] sect_mask;

  always_comb begin
    logic [1:0] level;
    if (a_q < p22_q) begin
      level = 2'd0;
    end else if (a_q < p67_q) begin
      level = 2'd1;
    end else begin
      level = 2'd2;
    end
    idx       = neg2_q ? (3'd2 - 3'(level)) : (3'd2 + 3'(level));
    sect_mask = xpos2_q ? chlo_pkg::MAP_POS[idx] : chlo_pkg::MAP_NEG[idx];
  end

  logic [SQW-1:0] hsum_q, az2_3_q;
  logic [S2W-1:0] sxy2_3_q, sz2_3_q;
  logic [7:0]     mask3_q;
  logic           nz3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hsum_q   <= ax2_q + ay2_q;
      az2_3_q  <= az2_2_q;
      sxy2_3_q <= sxy2_2_q;
      sz2_3_q  <= sz2_2_q;
      mask3_q  <= sect_mask;
      nz3_q    <= nz2_q;
    end
  end

  // stage 4: test products
  logic [MW-1:0] ml_q, mr_q;
  logic [7:0]    mask4_q;
  logic          nz4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ml_q    <= MW'(hsum_q) * MW'(sz2_3_q);
      mr_q    <= MW'(az2_3_q) * MW'(sxy2_3_q);
      mask4_q <= mask3_q;
      nz4_q   <= nz3_q;
    end
  end

  // stage 5: scale, compare, select
  logic [CW-1:0] lhs, rhs;
  logic [7:0]    mask_d;
  logic          flag_d;

  assign lhs = (CW'(ml_q) << 4) + (CW'(ml_q) << 3) + CW'(ml_q);
  assign rhs = CW'(mr_q) << 6;

  always_comb begin
    mask_d = 8'h00;
    flag_d = 1'b0;
    if (cfg.enable) begin
      if (lhs > rhs) begin
        mask_d = chlo_pkg::MASK_NOISY;
        flag_d = 1'b1;
      end else if (nz4_q) begin
        mask_d = mask4_q;
      end
    end
  end

  logic [7:0] mask_q;
  logic       flag_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mask_q <= mask_d;
      flag_q <= flag_d;
    end
  end

  assign m_axis_tdata = mask_q;
  assign m_axis_tuser = flag_q;

endmodule
